// ===== design/qwsc_pkg.sv =====
package qwsc_pkg;

  localparam int WINDOW_DEPTH_DEF = 5;

  localparam int GAIN_W   = 12;
  localparam int CNT_W    = 16;
  localparam int TGT_W    = 8;
  localparam int WIN_W    = 17;
  localparam int SUM_W    = 20;
  localparam int DIST_W   = 32;
  localparam int DUTY_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Intermediate widths of the command calculation.
  localparam int TSC_W   = 21;
  localparam int ERR8_W  = 29;
  localparam int ERR16_W = 42;
  localparam int HALF_W  = 21;
  localparam int PLO_W   = 33;
  localparam int PHI_W   = 34;
  localparam int CMD24_W = 55;
  localparam int CMD_W   = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_GAIN         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ERROR_GAIN = 2'd2;

  localparam logic [GAIN_W-1:0] SPEED_SCALE_RST      = 12'd384;
  localparam logic [GAIN_W-1:0] VEL_GAIN_RST         = 12'd384;
  localparam logic [GAIN_W-1:0] ACCEL_ERROR_GAIN_RST = 12'd205;

  localparam logic [DUTY_W-1:0] BRAKE_DUTY = 7'd99;
  localparam logic [DUTY_W-1:0] MAX_DUTY   = 7'd100;
  localparam int               BRAKE_LIMIT = 10;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [GAIN_W-1:0] speed_scale;
    logic [GAIN_W-1:0] vel_gain;
    logic [GAIN_W-1:0] accel_error_gain;
  } gains_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic signed [TGT_W-1:0] target;
    logic                    clear;
  } tick_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPD,
    BK_E8,
    BK_E16,
    BK_MLO,
    BK_MHI,
    BK_FIN
  } back_state_t;

endpackage

// ===== design/qwsc_front.sv =====
module qwsc_front import qwsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic                    in_channel,
  input  logic                    in_level,
  input  logic signed [TGT_W-1:0] in_target_speed,
  input  logic                    in_clear_distance,
  input  logic                    q_full,
  output logic                    q_push,
  output tick_t                   q_data
);

  logic                    accept;
  logic                    edge_take;
  logic                    up;
  logic signed [CNT_W-1:0] cnt_r;
  logic signed [CNT_W-1:0] cnt_nxt;
  logic                    last_valid_r;
  logic                    last_phase_r;
  logic                    phase_a_r;
  logic                    phase_b_r;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // An edge on the same phase as the previous counted edge is dropped.
  assign edge_take = accept && !in_func && !(last_valid_r && (last_phase_r == in_channel));
  assign up = in_channel ? (in_level != phase_a_r) : (in_level == phase_b_r);

  assign q_push        = accept && in_func;
  assign q_data.count  = cnt_r;
  assign q_data.target = in_target_speed;
  assign q_data.clear  = in_clear_distance;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      cnt_nxt = '0;
    end else if (edge_take) begin
      if (up) begin
        if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + 16'sd1;
      end else begin
        if (cnt_r != CNT_MIN) cnt_nxt = cnt_r - 16'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      last_valid_r <= 1'b0;
      last_phase_r <= 1'b0;
      phase_a_r    <= 1'b0;
      phase_b_r    <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (edge_take) begin
        last_valid_r <= 1'b1;
        last_phase_r <= in_channel;
        if (in_channel) phase_b_r <= in_level;
        else            phase_a_r <= in_level;
      end
    end
  end

endmodule

// ===== design/qwsc_fifo.sv =====
module qwsc_fifo import qwsc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  tick_t wr_data,
  input  logic  pop,
  output tick_t rd_data,
  output logic  full,
  output logic  empty
);

  tick_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/qwsc_back.sv =====
module qwsc_back import qwsc_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gains_t                   gains,
  input  logic                     q_empty,
  input  tick_t                    q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SUM_W-1:0]  out_measured_speed,
  output logic signed [DIST_W-1:0] out_distance,
  output logic [DUTY_W-1:0]        out_duty,
  output logic                     out_forward,
  output logic                     out_reverse
);

  localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  back_state_t state_r;
  back_state_t state_nxt;
  logic        out_load;

  tick_t                     tick_r;
  logic signed [WIN_W-1:0]   win_r [WINDOW_DEPTH];
  logic [POS_W-1:0]          pos_r;
  logic [POS_W-1:0]          pos_nxt;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   prev_r;
  logic [DIST_W-1:0]         travelled_r;
  logic [DIST_W-1:0]         dist_r;
  logic signed [TSC_W-1:0]   tsc_r;
  logic signed [ERR8_W-1:0]  err8_r;
  logic signed [SUM_W-1:0]   accel_r;
  logic signed [ERR16_W-1:0] err16_r;
  logic [PLO_W-1:0]          plo_r;
  logic signed [CMD24_W-1:0] cmd24_r;

  logic signed [WIN_W-1:0]   doubled;
  logic signed [SUM_W-1:0]   sum_new;
  logic [DIST_W-1:0]         dist_new;
  logic signed [TSC_W-1:0]   tsc_prod;
  logic signed [27:0]        sum_sh;
  logic signed [35:0]        accel_sh;
  logic signed [ERR16_W-1:0] e16_prod;
  logic [PLO_W-1:0]          plo_prod;
  logic signed [PHI_W-1:0]   phi_prod;
  logic signed [CMD_W-1:0]   cmd_floor;
  logic signed [CMD_W-1:0]   cmd;
  logic [CMD_W-1:0]          mag;
  logic                      brake;

  logic signed [SUM_W-1:0]   meas_r;
  logic [DIST_W-1:0]         odist_r;
  logic [DUTY_W-1:0]         duty_r;
  logic                      fwd_r;
  logic                      rev_r;
  logic                      out_valid_r;

  assign doubled  = {tick_r.count, 1'b0};
  assign sum_new  = sum_r - SUM_W'(win_r[pos_r]) + SUM_W'(doubled);
  assign dist_new = travelled_r + DIST_W'(tick_r.count);
  assign pos_nxt  = (pos_r == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_r + 1'b1;

  assign tsc_prod = TSC_W'(tick_r.target) * TSC_W'($signed({1'b0, gains.speed_scale}));
  assign sum_sh   = {sum_r, 8'd0};
  assign accel_sh = {accel_r, 16'd0};
  assign e16_prod = ERR16_W'(err8_r) * ERR16_W'($signed({1'b0, gains.vel_gain}));
  assign plo_prod = PLO_W'(err16_r[HALF_W-1:0]) * PLO_W'(gains.accel_error_gain);
  assign phi_prod = PHI_W'($signed(err16_r[ERR16_W-1:HALF_W]))
                  * PHI_W'($signed({1'b0, gains.accel_error_gain}));

  // The product is Q.24; shifting rounds toward minus infinity, so negative
  // values with a nonzero fraction get one added back.
  assign cmd_floor = cmd24_r[CMD24_W-1:24];
  assign cmd   = cmd_floor + CMD_W'(cmd24_r[CMD24_W-1] && (cmd24_r[23:0] != '0));
  assign mag   = cmd[CMD_W-1] ? CMD_W'(-cmd) : CMD_W'(cmd);
  assign brake = (mag <= CMD_W'(BRAKE_LIMIT));

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_UPD;
        end
      end
      BK_UPD: state_nxt = BK_E8;
      BK_E8:  state_nxt = BK_E16;
      BK_E16: state_nxt = BK_MLO;
      BK_MLO: state_nxt = BK_MHI;
      BK_MHI: state_nxt = BK_FIN;
      BK_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) win_r[i] <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      prev_r      <= '0;
      travelled_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == BK_UPD) begin
        win_r[pos_r] <= doubled;
        pos_r        <= pos_nxt;
        sum_r        <= sum_new;
        travelled_r  <= tick_r.clear ? '0 : dist_new;
      end
      if (state_r == BK_E8) prev_r <= sum_r;
      if (out_load)                  out_valid_r <= 1'b1;
      else if (!out_stall)           out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) tick_r <= q_data;
    case (state_r)
      BK_UPD: begin
        dist_r <= dist_new;
        tsc_r  <= tsc_prod;
      end
      BK_E8: begin
        err8_r  <= ERR8_W'(tsc_r) - ERR8_W'(sum_sh);
        accel_r <= sum_r - prev_r;
      end
      BK_E16: err16_r <= e16_prod - ERR16_W'(accel_sh);
      BK_MLO: plo_r   <= plo_prod;
      BK_MHI: cmd24_r <= (CMD24_W'(phi_prod) <<< HALF_W) + CMD24_W'(plo_r);
      default: ;
    endcase
    if (out_load) begin
      meas_r  <= sum_r;
      odist_r <= dist_r;
      if (brake) begin
        fwd_r  <= 1'b1;
        rev_r  <= 1'b1;
        duty_r <= BRAKE_DUTY;
      end else begin
        fwd_r  <= !cmd[CMD_W-1];
        rev_r  <= cmd[CMD_W-1];
        duty_r <= (mag > CMD_W'(MAX_DUTY)) ? MAX_DUTY : mag[DUTY_W-1:0];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_measured_speed = meas_r;
  assign out_distance       = odist_r;
  assign out_duty           = duty_r;
  assign out_forward        = fwd_r;
  assign out_reverse        = rev_r;

endmodule

// ===== design/quadrature_wheel_speed_controller_top.sv =====
// Speed loop for one wheel; use one instance per wheel.
// Input channel (in_valid / in_stall): an item is either an encoder edge
// (in_func low, in_channel and in_level give the phase that changed and its
// new level) or a control tick (in_func high, in_target_speed and
// in_clear_distance). Edges update a saturating position counter and give no
// result. Each tick gives exactly one result item on the output channel
// (out_valid / out_stall): the moving speed sum, the travelled distance and
// the motor drive (duty, forward, reverse; both pins high means brake).
// Edges are taken one per cycle while the queue is not full. A tick is
// queued and then worked through a six-step sequencer (window update, then
// the chain of gain products); it takes the next tick off the queue only
// once the last result is loaded, so the sequencer is the limit. A two-entry
// queue lets edges and ticks keep arriving while a tick is worked on;
// in_stall rises only when the queue is full. If the receiver stalls, the
// result is held in the output register and the sequencer waits on its
// last step. Gains are written on the cfg_ port (always ready); the user
// must write them only while idle, which the block does not enforce.
// Synchronous reset clears the counter, speed window, distance and
// restores the default gains; the block is ready the cycle after reset.
module quadrature_wheel_speed_controller_top import qwsc_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic                     in_channel,
  input  logic                     in_level,
  input  logic signed [TGT_W-1:0]  in_target_speed,
  input  logic                     in_clear_distance,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SUM_W-1:0]  out_measured_speed,
  output logic signed [DIST_W-1:0] out_distance,
  output logic [DUTY_W-1:0]        out_duty,
  output logic                     out_forward,
  output logic                     out_reverse,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [GAIN_W-1:0]        cfg_wdata
);

  gains_t gains_r;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  tick_t  q_wr;
  tick_t  q_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.speed_scale      <= SPEED_SCALE_RST;
      gains_r.vel_gain         <= VEL_GAIN_RST;
      gains_r.accel_error_gain <= ACCEL_ERROR_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPEED_SCALE:      gains_r.speed_scale      <= cfg_wdata;
        CFG_VEL_GAIN:         gains_r.vel_gain         <= cfg_wdata;
        CFG_ACCEL_ERROR_GAIN: gains_r.accel_error_gain <= cfg_wdata;
        default: ;
      endcase
    end
  end

  qwsc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_channel        (in_channel),
    .in_level          (in_level),
    .in_target_speed   (in_target_speed),
    .in_clear_distance (in_clear_distance),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_wr)
  );

  qwsc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  qwsc_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .gains              (gains_r),
    .q_empty            (q_empty),
    .q_data             (q_rd),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_measured_speed (out_measured_speed),
    .out_distance       (out_distance),
    .out_duty           (out_duty),
    .out_forward        (out_forward),
    .out_reverse        (out_reverse)
  );

endmodule

// ===== design/qwsc_checker.sv =====
module qwsc_checker import qwsc_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DIST_W-1:0] out_distance,
  input logic [DUTY_W-1:0]        out_duty,
  input logic                     out_forward,
  input logic                     out_reverse
);

  // No result may survive a reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance) && $stable(out_duty))
    else $error("stalled result changed");

  // Both pins high is the brake and always carries the brake duty.
  a_brake_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forward && out_reverse |-> out_duty == BRAKE_DUTY)
    else $error("brake with wrong duty");

  a_drive_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_forward != out_reverse) |->
      (out_duty > 7'(BRAKE_LIMIT)) && (out_duty <= MAX_DUTY))
    else $error("drive duty out of range");

  a_some_pin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_forward || out_reverse)
    else $error("no direction pin set");

endmodule

bind quadrature_wheel_speed_controller_top qwsc_checker u_qwsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_distance (out_distance),
  .out_duty     (out_duty),
  .out_forward  (out_forward),
  .out_reverse  (out_reverse)
);
